### rtl/core/phcc_pkg.sv
package phcc_pkg;

    localparam int KEY_BITS       = 64;
    localparam int TOKEN_BITS     = 48;
    localparam int TOTAL_BITS     = TOKEN_BITS + 1;
    localparam int TRACE_BITS     = 16;
    localparam int STRIDE_BITS    = 13;
    localparam int MAX_STRIDE     = 4096;
    localparam int POS_BITS       = $clog2(MAX_STRIDE);
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int HASH_SHL = 12;
    localparam int HASH_SHR = 32;
    localparam logic [KEY_BITS-1:0] GOLDEN_ADD = 64'h9e37_79b9_7f4a_7c15;

    // result queue: two entries per request plus room for the head in flight
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = QUEUE_PTR_BITS + 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HASH_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRACE_TOKENS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIDE       = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NEG_LEN  = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef enum logic {
        KIND_KEY    = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [KEY_BITS-1:0]  key;
        status_t              status;
        logic                 last;
    } result_t;

endpackage

### rtl/core/prefix_hash_chain_coarsener.sv
// Channel   Signals                                   Direction
// -------   ---------------------------------------   ---------
// in        in_valid/in_stall, key_value, token_len,   input
//           request_end
// out       out_valid/out_stall, result_kind,          output
//           coarse_key, status, last_result
// cfg       cfg_we, cfg_index, cfg_wdata               input
//
// One key per cycle while in_stall is low: a request goes into an input
// register and, once the queue has room, the hash chain, stride counter
// and token total are updated and the results go into a four-entry result
// queue. An end key with an emitted key makes two results in two entries.
// in_stall rises when the input register is full and the queue has fewer
// than two free entries. Reset clears configuration to its defaults, the
// request state and the queue; no clearing pass.
module prefix_hash_chain_coarsener
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [phcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [phcc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [phcc_pkg::KEY_BITS-1:0]         key_value,
    input  logic signed [phcc_pkg::TOKEN_BITS-1:0] token_len,
    input  logic                                  request_end,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  result_kind,
    output logic [phcc_pkg::KEY_BITS-1:0]         coarse_key,
    output logic [phcc_pkg::STATUS_BITS-1:0]      status,
    output logic                                  last_result
);
    import phcc_pkg::*;

    // configuration
    logic                     hash_enable_reg;
    logic [TRACE_BITS-1:0]    trace_tokens_reg;
    logic [STRIDE_BITS-1:0]   stride_reg;

    // input register
    logic                     in_valid_reg;
    logic [KEY_BITS-1:0]      key_reg;
    logic [TOKEN_BITS-1:0]    len_reg;
    logic                     end_reg;

    // request state
    logic [KEY_BITS-1:0]      hash_reg, hash_next;
    logic [POS_BITS-1:0]      pos_reg, pos_next;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;

    // result queue
    result_t                  queue_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    logic                     in_accept;
    logic                     advance;
    logic                     pop;

    logic [TRACE_BITS-1:0]    trace_eff;
    logic [STRIDE_BITS-1:0]   stride_eff;
    logic [KEY_BITS-1:0]      hash_mix;
    logic [KEY_BITS-1:0]      hash_new;
    logic [KEY_BITS-1:0]      chained;
    logic [STRIDE_BITS-1:0]   pos_inc;
    logic                     emit;
    logic [TOTAL_BITS:0]      sum_now;
    logic [TOTAL_BITS-1:0]    total_sat;
    logic [TOTAL_BITS:0]      sum_ahead;
    logic [TOTAL_BITS:0]      len_ext;
    logic                     mismatch;
    status_t                  end_status;
    result_t                  key_result;
    result_t                  status_result;
    result_t                  first_result;
    logic                     push_first;
    logic                     push_second;
    logic [QUEUE_CNT_BITS-1:0] push_count;

    // handshakes; the queue must hold two more results before an item moves on
    assign in_accept = in_valid && !in_stall;
    assign advance   = in_valid_reg && (count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_enable_reg  <= 1'b1;
            trace_tokens_reg <= TRACE_BITS'(1);
            stride_reg       <= STRIDE_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HASH_ENABLE:  hash_enable_reg  <= cfg_wdata[0];
                CFG_TRACE_TOKENS: trace_tokens_reg <= cfg_wdata[TRACE_BITS-1:0];
                CFG_STRIDE:       stride_reg       <= cfg_wdata[STRIDE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // zero trace size acts as one; stride is clamped to 1..MAX_STRIDE
    always_comb
    begin
        trace_eff = (trace_tokens_reg == '0) ? TRACE_BITS'(1) : trace_tokens_reg;
        if (stride_reg == '0)
            stride_eff = STRIDE_BITS'(1);
        else if (stride_reg > STRIDE_BITS'(MAX_STRIDE))
            stride_eff = STRIDE_BITS'(MAX_STRIDE);
        else
            stride_eff = stride_reg;
    end

    // hash chain step
    assign hash_mix = key_reg + GOLDEN_ADD + (hash_reg << HASH_SHL) + (hash_reg >> HASH_SHR);
    assign hash_new = hash_reg ^ hash_mix;
    assign chained  = hash_enable_reg ? hash_new : key_reg;

    // stride position
    assign pos_inc = {1'b0, pos_reg} + STRIDE_BITS'(1);
    assign emit    = (pos_inc >= stride_eff);

    // token total saturates at all ones; the top sum bit is the overflow
    assign sum_now   = {1'b0, total_reg} + (TOTAL_BITS+1)'(trace_eff);
    assign total_sat = sum_now[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum_now[TOTAL_BITS-1:0];

    // count is right when total <= len < total + trace; a saturated look-ahead
    // is above any legal length, so the unsaturated sum gives the same answer
    assign sum_ahead = {1'b0, total_sat} + (TOTAL_BITS+1)'(trace_eff);
    assign len_ext   = {2'b00, len_reg};
    assign mismatch  = ({1'b0, total_sat} > len_ext) || (sum_ahead <= len_ext);

    always_comb
    begin
        if (len_reg[TOKEN_BITS-1])
            end_status = STATUS_NEG_LEN;
        else if (len_reg != '0 && mismatch)
            end_status = STATUS_MISMATCH;
        else
            end_status = STATUS_OK;
    end

    always_comb
    begin
        key_result.kind      = KIND_KEY;
        key_result.key       = chained;
        key_result.status    = STATUS_OK;
        key_result.last      = !end_reg;

        status_result.kind   = KIND_STATUS;
        status_result.key    = '0;
        status_result.status = end_status;
        status_result.last   = 1'b1;

        first_result = emit ? key_result : status_result;
        push_first   = advance && (emit || end_reg);
        push_second  = advance && emit && end_reg;
        push_count   = QUEUE_CNT_BITS'(push_first) + QUEUE_CNT_BITS'(push_second);
    end

    // request state; everything clears after the end key
    always_comb
    begin
        hash_next  = hash_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        if (advance)
        begin
            if (end_reg)
            begin
                hash_next  = '0;
                pos_next   = '0;
                total_next = '0;
            end
            else
            begin
                if (hash_enable_reg)
                    hash_next = hash_new;
                pos_next   = emit ? '0 : pos_inc[POS_BITS-1:0];
                total_next = total_sat;
            end
        end
    end

    assign count_next = count_reg + push_count - QUEUE_CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            hash_reg     <= '0;
            pos_reg      <= '0;
            total_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            hash_reg   <= hash_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(push_count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            count_reg  <= count_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg <= key_value;
            len_reg <= token_len;
            end_reg <= request_end;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push_first)
            queue_mem[wr_ptr_reg] <= first_result;
        if (push_second)
            queue_mem[wr_ptr_reg + QUEUE_PTR_BITS'(1)] <= status_result;
    end

    result_t head;
    assign head        = queue_mem[rd_ptr_reg];
    assign result_kind = head.kind;
    assign coarse_key  = head.key;
    assign status      = head.status;
    assign last_result = head.last;

endmodule

### rtl/core/phcc_port_checker.sv
module phcc_port_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  result_kind,
    input logic [phcc_pkg::KEY_BITS-1:0]         coarse_key,
    input logic [phcc_pkg::STATUS_BITS-1:0]      status,
    input logic                                  last_result
);
    import phcc_pkg::*;

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(coarse_key)
            && $stable(status) && $stable(last_result))
        else $error("stalled result changed");

    // status closes the request's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS |-> last_result && coarse_key == '0)
        else $error("status result malformed");

    // key results carry a zero status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_KEY |-> status == STATUS_OK)
        else $error("key result with nonzero status");

    // a key that is not last is followed by the status of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && result_kind == KIND_KEY && !last_result
            |=> out_valid && result_kind == KIND_STATUS)
        else $error("end key not followed by status");

    // status codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_NEG_LEN
            || status == STATUS_MISMATCH)
        else $error("status code out of range");

endmodule

bind prefix_hash_chain_coarsener phcc_port_checker u_phcc_port_checker (.*);

### sim/prefix_hash_chain_coarsener_test.sv
`timescale 1ns / 1ps

// Block-level test for the prefix hash chain coarsener.
// A directed table runs first, then randomized key runs under several
// register settings. Each accepted request goes through a local model of the
// chain, stride and token count. Each result is checked, in order, against
// what that model owes.
module prefix_hash_chain_coarsener_test;
    import phcc_pkg::*;

    localparam logic [KEY_BITS-1:0]   CHAIN_ADD       = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [TOTAL_BITS-1:0] TOTAL_CAP       = {TOTAL_BITS{1'b1}};
    localparam int                    STRIDE_CEIL     = 4096;
    localparam int                    SETTLE_CYCLES   = 8;
    localparam int                    HOLD_OFF_CYCLES = 120;
    localparam int                    RANDOM_PHASES   = 7;
    localparam int                    PHASE_KEYS      = 170;

    // one row of stimulus: either a register write or one keyed request,
    // optionally with the expected key and/or status typed in
    typedef struct {
        logic                      is_cfg;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_data;
        logic [KEY_BITS-1:0]       key;
        logic [TOKEN_BITS-1:0]     len;
        logic                      last_key;
        logic                      chk_key;
        logic [KEY_BITS-1:0]       want_key;
        logic                      chk_status;
        status_t                   want_status;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;
    logic                          in_valid;
    logic                          in_stall;
    logic [KEY_BITS-1:0]           key_value;
    logic signed [TOKEN_BITS-1:0]  token_len;
    logic                          request_end;
    logic                          out_valid;
    logic                          out_stall;
    logic                          result_kind;
    logic [KEY_BITS-1:0]           coarse_key;
    logic [STATUS_BITS-1:0]        status;
    logic                          last_result;

    // model copy of the registers (reset values) and per-run state
    logic                          hash_on      = 1'b1;
    logic [TRACE_BITS-1:0]         trace_tokens = 16'd1;
    logic [STRIDE_BITS-1:0]        stride_cfg   = 13'd1;
    logic [KEY_BITS-1:0]           chain_hash   = '0;
    logic [POS_BITS-1:0]           stride_pos   = '0;
    logic [TOTAL_BITS-1:0]         tokens_seen  = '0;

    result_t                       results_due[$];
    stim_row_t                     directed[$];
    int                            fault_count    = 0;
    int                            burst_left     = 0;
    int                            hold_off_asked = 0;

    prefix_hash_chain_coarsener dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_value   (key_value),
        .token_len   (token_len),
        .request_end (request_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .coarse_key  (coarse_key),
        .status      (status),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500_000;
        $display("DONE: errors detected");
        $finish;
    end

    // zero trace size counts as one token per key
    function automatic logic [TRACE_BITS-1:0] trace_eff();
        return (trace_tokens == 0) ? 16'd1 : trace_tokens;
    endfunction

    // stride of zero acts as one, anything past the ceiling is clamped
    function automatic int stride_eff();
        if (stride_cfg == 0)
            return 1;
        if (stride_cfg > STRIDE_CEIL)
            return STRIDE_CEIL;
        return int'(stride_cfg);
    endfunction

    // token total saturates; the cap is above any legal length
    function automatic logic [TOTAL_BITS-1:0] add_capped(input logic [TOTAL_BITS-1:0] total,
                                                         input logic [TRACE_BITS-1:0] t);
        logic [TOTAL_BITS:0] sum;
        sum = {1'b0, total} + {{(TOTAL_BITS + 1 - TRACE_BITS){1'b0}}, t};
        return (sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : sum[TOTAL_BITS-1:0];
    endfunction

    // Advances chain, stride counter and token total by one accepted key.
    // Returns the number of results owed: a coarse key, an end status, or both.
    function automatic int chain_and_coarsen(input logic [KEY_BITS-1:0] key,
                                             input logic [TOKEN_BITS-1:0] len,
                                             input logic last_key,
                                             output result_t made [2]);
        logic [KEY_BITS-1:0]   chained;
        logic [TRACE_BITS-1:0] t;
        logic                  emit;
        status_t               verdict;
        int                    n;
        n = 0;
        t = trace_eff();
        if (hash_on)
        begin
            chain_hash = chain_hash ^ (key + CHAIN_ADD + (chain_hash << 12) + (chain_hash >> 32));
            chained = chain_hash;
        end
        else
        begin
            chained = key;
        end
        emit = (int'(stride_pos) + 1 >= stride_eff());
        stride_pos = emit ? '0 : stride_pos + 1'b1;
        tokens_seen = add_capped(tokens_seen, t);
        if (emit)
        begin
            made[n] = '{KIND_KEY, chained, STATUS_OK, ~last_key};
            n++;
        end
        if (last_key)
        begin
            // count must equal floor(len / t): total <= len < total + t
            verdict = STATUS_OK;
            if (len[TOKEN_BITS-1])
                verdict = STATUS_NEG_LEN;
            else if (len != 0 && (tokens_seen > len || add_capped(tokens_seen, t) <= len))
                verdict = STATUS_MISMATCH;
            made[n] = '{KIND_STATUS, '0, verdict, 1'b1};
            n++;
            chain_hash  = '0;
            stride_pos  = '0;
            tokens_seen = '0;
        end
        return n;
    endfunction

    function automatic stim_row_t key_row(input logic [KEY_BITS-1:0] key,
                                          input logic [TOKEN_BITS-1:0] len,
                                          input logic last_key,
                                          input logic chk_key,
                                          input logic [KEY_BITS-1:0] want_key,
                                          input logic chk_status,
                                          input status_t want_status);
        stim_row_t r;
        r.is_cfg      = 1'b0;
        r.reg_index   = CFG_HASH_ENABLE;
        r.reg_data    = '0;
        r.key         = key;
        r.len         = len;
        r.last_key    = last_key;
        r.chk_key     = chk_key;
        r.want_key    = want_key;
        r.chk_status  = chk_status;
        r.want_status = want_status;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t r;
        r = key_row('0, '0, 1'b0, 1'b0, '0, 1'b0, STATUS_OK);
        r.is_cfg    = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    // appends one row to the directed table
    function automatic void add_row(input stim_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    // length for the last key of a run: mostly right, often just off either
    // side of the window, sometimes zero, negative or anything at all
    function automatic logic [TOKEN_BITS-1:0] pick_len(input int n_keys);
        longint t;
        longint base;
        t    = longint'(trace_eff());
        base = longint'(n_keys) * t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 48'(base + longint'($urandom_range(0, int'(t) - 1)));
            4:          return '0;
            5:          return {1'b1, 15'($urandom), $urandom};
            6:          return 48'(base - 1);
            7:          return 48'(base + t);
            default:    return {16'($urandom), $urandom};
        endcase
    endfunction

    function automatic void flag_fault(input string what, input logic [KEY_BITS-1:0] want,
                                       input logic [KEY_BITS-1:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: bad %s, expected %h, got %h", $time, what, want, got);
    endfunction

    // Offer one request; bursts of back-to-back requests are broken by short
    // idle gaps. The model is advanced at the edge that accepts the request.
    task automatic offer_key(input stim_row_t r);
        result_t made [2];
        int      n;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        key_value   <= r.key;
        token_len   <= r.len;
        request_end <= r.last_key;
        do
            @(posedge clk);
        while (in_stall);
        n = chain_and_coarsen(r.key, r.len, r.last_key, made);
        for (int i = 0; i < n; i++)
        begin
            if (made[i].kind == KIND_KEY && r.chk_key)
                made[i].key = r.want_key;
            if (made[i].kind == KIND_STATUS && r.chk_status)
                made[i].status = r.want_status;
            results_due.insert(results_due.size(), made[i]);
        end
    endtask

    // drop valid, let every owed result drain, then give a non-emitting key
    // still in the pipe time to land before anything is reconfigured
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HASH_ENABLE:  hash_on      = data[0];
            CFG_TRACE_TOKENS: trace_tokens = data;
            CFG_STRIDE:       stride_cfg   = data[STRIDE_BITS-1:0];
            default:          ;
        endcase
    endtask

    // one run of keys; only the last carries request_end and a checked length
    task automatic send_run(input int n_keys, input logic [TOKEN_BITS-1:0] len);
        logic [KEY_BITS-1:0]   key;
        logic [TOKEN_BITS-1:0] noise_len;
        for (int i = 0; i < n_keys; i++)
        begin
            case ($urandom_range(0, 15))
                0:       key = '0;
                1:       key = '1;
                default: key = {$urandom, $urandom};
            endcase
            noise_len = {16'($urandom), $urandom};
            offer_key(key_row(key, (i == n_keys - 1) ? len : noise_len, i == n_keys - 1,
                              1'b0, '0, 1'b0, STATUS_OK));
        end
    endtask

    // result checker: every accepted result against the oldest one owed
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                flag_fault("unexpected result", '0, coarse_key);
            end
            else
            begin
                want = results_due.pop_front();
                if (result_kind !== want.kind)
                    flag_fault("result_kind", 64'(want.kind), 64'(result_kind));
                if (coarse_key !== want.key)
                    flag_fault("coarse_key", want.key, coarse_key);
                if (status !== want.status)
                    flag_fault("status", 64'(want.status), 64'(status));
                if (last_result !== want.last)
                    flag_fault("last_result", 64'(want.last), 64'(last_result));
            end
        end
    end

    // Receiver: windows of never / light / heavy / patterned stall, plus a
    // long hold-off whenever the stimulus asks for one so the result queue
    // fills and in_stall has to rise.
    initial
    begin : receiver
        int         mode;
        int         left;
        int         asked_seen;
        logic [7:0] pattern;
        out_stall  = 1'b0;
        mode       = 0;
        left       = 0;
        asked_seen = 0;
        pattern    = '0;
        forever
        begin
            @(negedge clk);
            if (asked_seen != hold_off_asked)
            begin
                asked_seen = hold_off_asked;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    left    = $urandom_range(16, 96);
                    pattern = 8'($urandom);
                end
                left--;
                pattern = {pattern[6:0], pattern[7]};
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= pattern[0];
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int keys_sent;
        int n_keys;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_HASH_ENABLE;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        key_value   = '0;
        token_len   = '0;
        request_end = 1'b0;

        // Reset settings: hashing on, one token per key, every key emitted.
        // A zero key into a cleared chain gives the golden constant itself.
        add_row(key_row('0, 48'd1, 1'b1, 1'b1, CHAIN_ADD, 1'b1, STATUS_OK));
        // all-ones key wraps the add; zero length is always accepted
        add_row(key_row('1, 48'd0, 1'b1, 1'b1, CHAIN_ADD - 1, 1'b1, STATUS_OK));
        // negative lengths, -1 and the most negative
        add_row(key_row('0, '1, 1'b1, 1'b1, CHAIN_ADD, 1'b1, STATUS_NEG_LEN));
        add_row(key_row('0, 48'h8000_0000_0000, 1'b1, 1'b1, CHAIN_ADD,
                        1'b1, STATUS_NEG_LEN));
        // largest positive length against a single key
        add_row(key_row(64'h0123_4567_89ab_cdef, 48'h7fff_ffff_ffff, 1'b1,
                        1'b0, '0, 1'b1, STATUS_MISMATCH));
        // three-key chain, exact length; length on inner keys is ignored
        add_row(key_row(64'hffff_0000_ffff_0000, 48'd0, 1'b0,
                        1'b0, '0, 1'b0, STATUS_OK));
        add_row(key_row(64'haaaa_aaaa_aaaa_aaaa, '1, 1'b0,
                        1'b0, '0, 1'b0, STATUS_OK));
        add_row(key_row(64'h5555_5555_5555_5555, 48'd3, 1'b1,
                        1'b0, '0, 1'b1, STATUS_OK));
        // two keys claimed as one token
        add_row(key_row(64'h1, 48'd0, 1'b0, 1'b0, '0, 1'b0, STATUS_OK));
        add_row(key_row(64'h2, 48'd1, 1'b1, 1'b0, '0, 1'b1, STATUS_MISMATCH));

        // hashing off: raw keys pass; zero trace size and zero stride act as one
        add_row(cfg_row(CFG_HASH_ENABLE, 16'd0));
        add_row(cfg_row(CFG_TRACE_TOKENS, 16'd0));
        add_row(cfg_row(CFG_STRIDE, 16'd0));
        add_row(key_row(64'hdead_beef_cafe_f00d, 48'd1, 1'b1,
                        1'b1, 64'hdead_beef_cafe_f00d, 1'b1, STATUS_OK));
        add_row(key_row(64'h8000_0000_0000_0001, 48'd2, 1'b1,
                        1'b1, 64'h8000_0000_0000_0001, 1'b1, STATUS_MISMATCH));

        // widest trace size, stride 3: keys 3 and 6 come out, the tail is dropped
        add_row(cfg_row(CFG_HASH_ENABLE, 16'd1));
        add_row(cfg_row(CFG_TRACE_TOKENS, 16'hffff));
        add_row(cfg_row(CFG_STRIDE, 16'd3));
        for (int i = 0; i < 7; i++)
            add_row(key_row(64'h1111_1111_1111_1111 * (i + 1),
                            48'd524279, i == 6, 1'b0, '0, 1'b0, STATUS_OK));
        // one token short of two full keys
        add_row(key_row(64'hf0f0_f0f0_f0f0_f0f0, 48'd0, 1'b0,
                        1'b0, '0, 1'b0, STATUS_OK));
        add_row(key_row(64'h0f0f_0f0f_0f0f_0f0f, 48'd131069, 1'b1,
                        1'b0, '0, 1'b1, STATUS_MISMATCH));

        // stride write past the ceiling clamps; a short run emits nothing
        add_row(cfg_row(CFG_STRIDE, 16'hffff));
        add_row(cfg_row(CFG_TRACE_TOKENS, 16'd1));
        add_row(key_row(64'h7777_0000_7777_0000, 48'd5, 1'b0,
                        1'b0, '0, 1'b0, STATUS_OK));
        add_row(key_row(64'h0000_7777_0000_7777, 48'd2, 1'b1,
                        1'b0, '0, 1'b1, STATUS_OK));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                if (i == 0 || !directed[i - 1].is_cfg)
                    settle();
                write_reg(directed[i].reg_index, directed[i].reg_data);
            end
            else
            begin
                offer_key(directed[i]);
            end
        end

        // random phases, each under a fresh setting with small strides
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            write_reg(CFG_HASH_ENABLE, 16'($urandom_range(0, 1)));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TRACE_TOKENS, 16'd0);
                1:       write_reg(CFG_TRACE_TOKENS, 16'd1);
                2:       write_reg(CFG_TRACE_TOKENS, 16'hffff);
                3:       write_reg(CFG_TRACE_TOKENS, 16'($urandom_range(2, 8)));
                4:       write_reg(CFG_TRACE_TOKENS, 16'($urandom_range(1, 300)));
                default: write_reg(CFG_TRACE_TOKENS, 16'($urandom));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_STRIDE, 16'd0);
                1:       write_reg(CFG_STRIDE, 16'd1);
                2:       write_reg(CFG_STRIDE, 16'd2);
                3:       write_reg(CFG_STRIDE, 16'($urandom_range(3, 8)));
                default: write_reg(CFG_STRIDE, 16'($urandom_range(9, 24)));
            endcase
            if (phase % 3 == 1)
                hold_off_asked++;
            keys_sent = 0;
            while (keys_sent < PHASE_KEYS)
            begin
                if ($urandom_range(0, 3) == 0)
                    n_keys = 1;
                else
                    n_keys = $urandom_range(1, 3 * stride_eff() + 2);
                if (n_keys > 40)
                    n_keys = 40;
                send_run(n_keys, pick_len(n_keys));
                keys_sent += n_keys;
            end
        end

        settle();
        fault_count += results_due.size();
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
